### src/ast_pkg.sv
// shared types and constants of the aging sighting table
`timescale 1ns / 1ps
`default_nettype none

package ast_pkg;

  // field widths
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned EVICT_W  = 7;
  localparam int unsigned AGE_W    = 8;

  // table size and register reset
  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 8'd10;

  // actions of an input item
  typedef enum logic [ACT_W-1:0] {
    ACT_REFRESH = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_LIST    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  // status of a result item
  typedef enum logic [STATUS_W-1:0] {
    ST_REFRESHED = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_DROPPED   = 2'd2,
    ST_DONE      = 2'd3
  } status_e;

  // one result item
  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    out_id;
    logic               out_kind;
    logic               item_valid;
    logic [EVICT_W-1:0] evicted_count;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

### src/ast_intf.sv
// channel interfaces of the aging sighting table
`timescale 1ns / 1ps
`default_nettype none

// input items
interface ast_in_if import ast_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ACT_W-1:0] action;
  logic [ID_W-1:0] entity_id;
  logic            entity_kind;

  modport source(output valid, output action, output entity_id, output entity_kind,
                 input ready);
  modport sink(input valid, input action, input entity_id, input entity_kind,
               output ready);
endinterface

// result items
interface ast_out_if import ast_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     out_id;
  logic                out_kind;
  logic                item_valid;
  logic [EVICT_W-1:0]  evicted_count;
  logic                last;

  modport source(output valid, output status, output out_id, output out_kind,
                 output item_valid, output evicted_count, output last, input ready);
  modport sink(input valid, input status, input out_id, input out_kind,
               input item_valid, input evicted_count, input last, output ready);
endinterface

// age limit register writes
interface ast_cfg_if import ast_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AGE_W-1:0] age_limit;

  modport source(output valid, output age_limit, input ready);
  modport sink(input valid, input age_limit, output ready);
endinterface

`default_nettype wire

### src/aging_sighting_table.sv
// top level of the aging sighting table
//
// Remembers up to TABLE_DEPTH entities, each an id, a kind and an age in ticks.
// Input channel in_i carries action, entity_id and entity_kind; an item is
// taken when valid and ready are both high. Actions: refresh, tick, list, clear.
// Output channel out_o carries one result item per input, or one per listed
// entry for a list, the final one marked by last.
// Configuration channel cfg_i writes age_limit (reset 10); it is always ready.
// Write it only while the block is idle; the block itself does not enforce this.
// Refresh, tick and list sweep every slot of the slot memory, one slot a cycle
// through its single read port while no list result is stalled; a clear goes
// straight to its final result. The next item is taken once the previous one
// has pushed its final result.
// Results go through one output register, so the next item may start while a
// result waits. When the receiver stalls, a list sweep pauses on the entry
// that cannot be pushed and the final push waits; nothing is lost.
// Reset empties the table at once (per-slot used bits) and needs no clearing
// pass; the slot contents themselves are not reset.
`timescale 1ns / 1ps
`default_nettype none

module aging_sighting_table import ast_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ast_in_if.sink    in_i,
  ast_out_if.source out_o,
  ast_cfg_if.sink   cfg_i
);

  logic [AGE_W-1:0] age_limit_q;
  logic out_valid_q;
  res_t out_q;
  logic out_free;
  logic idle;
  logic res_push;
  res_t res;

  // age limit register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_limit_q <= AGE_LIMIT_RST;
    end else if (cfg_i.valid) begin
      age_limit_q <= cfg_i.age_limit;
    end
  end

  // input handshake
  assign in_i.ready = idle;

  ast_engine #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_i.valid && in_i.ready),
    .action_i     (in_i.action),
    .entity_id_i  (in_i.entity_id),
    .entity_kind_i(in_i.entity_kind),
    .age_limit_i  (age_limit_q),
    .out_free_i   (out_free),
    .idle_o       (idle),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  // output register
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_q.status;
  assign out_o.out_id        = out_q.out_id;
  assign out_o.out_kind      = out_q.out_kind;
  assign out_o.item_valid    = out_q.item_valid;
  assign out_o.evicted_count = out_q.evicted_count;
  assign out_o.last          = out_q.last;

endmodule

`default_nettype wire

### src/ast_engine.sv
// slot memory and sweep sequencer of the aging sighting table
`timescale 1ns / 1ps
`default_nettype none

module ast_engine import ast_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [ACT_W-1:0] action_i,
  input  wire logic [ID_W-1:0]  entity_id_i,
  input  wire logic             entity_kind_i,
  input  wire logic [AGE_W-1:0] age_limit_i,
  input  wire logic             out_free_i,
  output logic                  idle_o,
  output logic                  res_push_o,
  output res_t                  res_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  typedef struct packed {
    logic             kind;
    logic [ID_W-1:0]  key;
    logic [AGE_W-1:0] age;
  } entry_t;

  // slot memory, one read and one write port
  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;
  logic [IDX_W-1:0] raddr;
  logic mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t mem_wdata;

  state_e state_q, state_d;
  action_e act_q, act_d;
  logic [ID_W-1:0] id_q, id_d;
  logic kind_q, kind_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic iss_q, iss_d;
  logic dv_q, dv_d;
  logic [IDX_W-1:0] di_q, di_d;
  logic [TABLE_DEPTH-1:0] used_q, used_d;
  logic found_q, found_d;
  logic free_ok_q, free_ok_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic [EVICT_W-1:0] evict_q, evict_d;
  logic pend_v_q, pend_v_d;
  logic [ID_W-1:0] pend_id_q, pend_id_d;

  logic used_hit;
  logic list_match;
  logic stall;
  logic [AGE_W:0] aged;

  assign idle_o = (state_q == S_IDLE);

  // data stage decode
  assign used_hit   = dv_q && used_q[di_q];
  assign list_match = (act_q == ACT_LIST) && used_hit && (rdata_q.kind == kind_q);
  assign stall      = (state_q == S_SCAN) && list_match && pend_v_q && !out_free_i;
  assign raddr      = stall ? di_q : cnt_q;
  assign aged       = {1'b0, rdata_q.age} + (AGE_W + 1)'(1);

  // sequencer
  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    id_d       = id_q;
    kind_d     = kind_q;
    cnt_d      = cnt_q;
    iss_d      = iss_q;
    dv_d       = dv_q;
    di_d       = di_q;
    used_d     = used_q;
    found_d    = found_q;
    free_ok_d  = free_ok_q;
    free_idx_d = free_idx_q;
    evict_d    = evict_q;
    pend_v_d   = pend_v_q;
    pend_id_d  = pend_id_q;
    mem_we     = 1'b0;
    mem_waddr  = di_q;
    mem_wdata  = '{kind: kind_q, key: id_q, age: '0};
    res_push_o = 1'b0;
    res_o      = '{status: ST_DONE, out_id: '0, out_kind: 1'b0, item_valid: 1'b0,
                   evicted_count: '0, last: 1'b1};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d     = action_e'(action_i);
          id_d      = entity_id_i;
          kind_d    = entity_kind_i;
          cnt_d     = '0;
          iss_d     = 1'b1;
          dv_d      = 1'b0;
          found_d   = 1'b0;
          free_ok_d = 1'b0;
          evict_d   = '0;
          pend_v_d  = 1'b0;
          state_d   = (action_e'(action_i) == ACT_CLEAR) ? S_FINISH : S_SCAN;
        end
      end

      S_SCAN: begin
        if (!stall) begin
          // issue stage
          dv_d = iss_q;
          di_d = cnt_q;
          if (iss_q) begin
            cnt_d = cnt_q + IDX_W'(1);
            if (cnt_q == LAST_IDX) begin
              iss_d = 1'b0;
            end
          end else begin
            state_d = S_FINISH;
          end

          // data stage
          case (act_q)
            ACT_REFRESH: begin
              if (used_hit && rdata_q.key == id_q && rdata_q.kind == kind_q) begin
                found_d = 1'b1;
                mem_we  = 1'b1;
              end else if (dv_q && !used_q[di_q] && !free_ok_q) begin
                free_ok_d  = 1'b1;
                free_idx_d = di_q;
              end
            end
            ACT_TICK: begin
              if (used_hit) begin
                if (aged > {1'b0, age_limit_i}) begin
                  used_d[di_q] = 1'b0;
                  evict_d      = evict_q + EVICT_W'(1);
                end else begin
                  mem_we    = 1'b1;
                  mem_wdata = '{kind: rdata_q.kind, key: rdata_q.key,
                                age: aged[AGE_W] ? '1 : aged[AGE_W-1:0]};
                end
              end
            end
            ACT_LIST: begin
              if (list_match) begin
                if (pend_v_q) begin
                  res_push_o = 1'b1;
                  res_o      = '{status: ST_DONE, out_id: pend_id_q, out_kind: kind_q,
                                 item_valid: 1'b1, evicted_count: '0, last: 1'b0};
                end
                pend_v_d  = 1'b1;
                pend_id_d = rdata_q.key;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_FINISH: begin
        if (out_free_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
          case (act_q)
            ACT_REFRESH: begin
              if (found_q) begin
                res_o.status = ST_REFRESHED;
              end else if (free_ok_q) begin
                res_o.status       = ST_INSERTED;
                mem_we             = 1'b1;
                mem_waddr          = free_idx_q;
                used_d[free_idx_q] = 1'b1;
              end else begin
                res_o.status = ST_DROPPED;
              end
            end
            ACT_TICK: begin
              res_o.evicted_count = evict_q;
            end
            ACT_LIST: begin
              if (pend_v_q) begin
                res_o.out_id     = pend_id_q;
                res_o.out_kind   = kind_q;
                res_o.item_valid = 1'b1;
              end
            end
            default: begin
              used_d = '0;
            end
          endcase
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // slot memory access
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iss_q   <= 1'b0;
      dv_q    <= 1'b0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      dv_q    <= dv_d;
      used_q  <= used_d;
    end
  end

  // working registers of the current item
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    id_q       <= id_d;
    kind_q     <= kind_d;
    cnt_q      <= cnt_d;
    di_q       <= di_d;
    found_q    <= found_d;
    free_ok_q  <= free_ok_d;
    free_idx_q <= free_idx_d;
    evict_q    <= evict_d;
    pend_v_q   <= pend_v_d;
    pend_id_q  <= pend_id_d;
  end

endmodule

`default_nettype wire

### sim/aging_sighting_table_test.sv
// self-checking testbench of the aging sighting table
`timescale 1ns / 1ps

module aging_sighting_table_test import ast_pkg::*; ();

  localparam int unsigned TABLE_DEPTH   = TABLE_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = TABLE_DEPTH + 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned ID_POOL_N     = 24;
  localparam int unsigned PHASE_ITEMS   = 32;
  localparam logic        KIND_PERSON   = 1'b0;
  localparam logic        KIND_VEHICLE  = 1'b1;

  // idling modes
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // shadow of the table that works out the due result items
  class sighting_scoreboard;
    bit               slot_used[TABLE_DEPTH];
    logic [ID_W-1:0]  slot_key[TABLE_DEPTH];
    logic             slot_kind[TABLE_DEPTH];
    logic [AGE_W-1:0] slot_age[TABLE_DEPTH];
    logic [AGE_W-1:0] age_limit;
    res_t             due_results[$];
    int unsigned      errors;

    function new();
      age_limit = AGE_LIMIT_RST;
      errors    = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function void write_limit(logic [AGE_W-1:0] value);
      age_limit = value;
    endfunction

    function res_t make_res(status_e st, logic [ID_W-1:0] id, logic k, logic iv,
                            logic [EVICT_W-1:0] evicted, logic lst);
      res_t r;
      r.status        = st;
      r.out_id        = id;
      r.out_kind      = k;
      r.item_valid    = iv;
      r.evicted_count = evicted;
      r.last          = lst;
      return r;
    endfunction

    // append one result item to the due list
    function void queue_due(res_t r);
      due_results = {due_results, r};
    endfunction

    // apply one accepted input item and queue the results it causes
    function void predict_results(action_e act, logic [ID_W-1:0] id, logic k);
      int          free_slot;
      int unsigned evicted;
      int unsigned aged;
      int          listed;
      free_slot = -1;
      evicted   = 0;
      listed    = 0;
      case (act)
        ACT_REFRESH: begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_used[i]) begin
              if (slot_key[i] == id && slot_kind[i] == k) begin
                slot_age[i] = '0;
                queue_due(make_res(ST_REFRESHED, '0, 1'b0, 1'b0, '0, 1'b1));
                return;
              end
            end else if (free_slot < 0) begin
              free_slot = i;
            end
          end
          if (free_slot < 0) begin
            queue_due(make_res(ST_DROPPED, '0, 1'b0, 1'b0, '0, 1'b1));
          end else begin
            slot_used[free_slot] = 1'b1;
            slot_key[free_slot]  = id;
            slot_kind[free_slot] = k;
            slot_age[free_slot]  = '0;
            queue_due(make_res(ST_INSERTED, '0, 1'b0, 1'b0, '0, 1'b1));
          end
        end
        ACT_TICK: begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_used[i]) begin
              aged = slot_age[i] + 1;
              if (aged > age_limit) begin
                slot_used[i] = 1'b0;
                evicted++;
              end else begin
                slot_age[i] = (aged > 255) ? 8'd255 : aged[AGE_W-1:0];
              end
            end
          end
          queue_due(make_res(ST_DONE, '0, 1'b0, 1'b0, evicted[EVICT_W-1:0], 1'b1));
        end
        ACT_LIST: begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_used[i] && slot_kind[i] == k) begin
              queue_due(make_res(ST_DONE, slot_key[i], slot_kind[i], 1'b1, '0, 1'b0));
              listed++;
            end
          end
          if (listed == 0) begin
            queue_due(make_res(ST_DONE, '0, 1'b0, 1'b0, '0, 1'b1));
          end else begin
            due_results[due_results.size()-1].last = 1'b1;
          end
        end
        default: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
          queue_due(make_res(ST_DONE, '0, 1'b0, 1'b0, '0, 1'b1));
        end
      endcase
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    endfunction

    // compare one accepted result item with the oldest due one
    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) report_field("status", want.status, got.status);
      if (got.out_id !== want.out_id) report_field("out_id", want.out_id, got.out_id);
      if (got.out_kind !== want.out_kind)
        report_field("out_kind", want.out_kind, got.out_kind);
      if (got.item_valid !== want.item_valid)
        report_field("item_valid", want.item_valid, got.item_valid);
      if (got.evicted_count !== want.evicted_count)
        report_field("evicted_count", want.evicted_count, got.evicted_count);
      if (got.last !== want.last) report_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ast_in_if  in_if();
  ast_out_if out_if();
  ast_cfg_if cfg_if();

  sighting_scoreboard sb;

  int unsigned     src_idle_pct;
  int unsigned     snk_stall_pct;
  bit              hold_req;
  int unsigned     hold_left;
  logic [ID_W-1:0] id_pool[ID_POOL_N];
  res_t            got_res;

  aging_sighting_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #20ms;
    $display("FAIL aging_sighting_table");
    $finish;
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // watch all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_limit(cfg_if.age_limit);
      if (in_if.valid && in_if.ready)
        sb.predict_results(action_e'(in_if.action), in_if.entity_id, in_if.entity_kind);
      if (out_if.valid && out_if.ready) begin
        got_res.status        = status_e'(out_if.status);
        got_res.out_id        = out_if.out_id;
        got_res.out_kind      = out_if.out_kind;
        got_res.item_valid    = out_if.item_valid;
        got_res.evicted_count = out_if.evicted_count;
        got_res.last          = out_if.last;
        sb.check_result(got_res);
      end
    end
  end

  task automatic set_idling(idle_mode_e mode);
    src_idle_pct  = (mode == IDLE_SENDER) ? 62 : (mode == IDLE_BOTH) ? 16 : 0;
    snk_stall_pct = (mode == IDLE_RECEIVER) ? 62 : (mode == IDLE_BOTH) ? 16 : 0;
  endtask

  // offer one input item and wait until it is taken
  task automatic send_item(action_e act, logic [ID_W-1:0] id, logic k);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.entity_id   <= id;
    in_if.entity_kind <= k;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // stop offering and wait for every due result, then let the block settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_age_limit(logic [AGE_W-1:0] value);
    cfg_if.valid     <= 1'b1;
    cfg_if.age_limit <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // random items; ids mostly from a small pool so that refreshes hit
  task automatic run_random(int unsigned n, int unsigned w_ref, int unsigned w_tick,
                            int unsigned w_list);
    int unsigned     r;
    action_e         act;
    logic [ID_W-1:0] id;
    for (int unsigned j = 0; j < n; j++) begin
      r = $urandom_range(99);
      if (r < w_ref) act = ACT_REFRESH;
      else if (r < w_ref + w_tick) act = ACT_TICK;
      else if (r < w_ref + w_tick + w_list) act = ACT_LIST;
      else act = ACT_CLEAR;
      if ($urandom_range(7) == 0) id = ID_W'($urandom_range(16'hFFFF));
      else id = id_pool[$urandom_range(ID_POOL_N-1)];
      send_item(act, id, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [AGE_W-1:0] phase_limit[8];
    sb                = new();
    rst_ni            = 1'b0;
    hold_req          = 1'b0;
    hold_left         = 0;
    in_if.valid       = 1'b0;
    in_if.action      = ACT_REFRESH;
    in_if.entity_id   = '0;
    in_if.entity_kind = KIND_PERSON;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.age_limit  = AGE_LIMIT_RST;
    set_idling(IDLE_NONE);
    id_pool[0] = '0;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < ID_POOL_N; i++) id_pool[i] = ID_W'($urandom_range(16'hFFFF));
    phase_limit = '{8'd1, 8'd4, 8'd255, 8'd2, 8'd0, 8'd6, 8'd3, 8'd12};
    phase_limit[4] = AGE_W'($urandom_range(255, 1));

    // reset
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, insert, refresh, same id other kind, list, tick, clear
    send_item(ACT_LIST, 16'h0000, KIND_PERSON);
    send_item(ACT_REFRESH, 16'h0000, KIND_PERSON);
    send_item(ACT_REFRESH, 16'hFFFF, KIND_VEHICLE);
    send_item(ACT_REFRESH, 16'h0000, KIND_PERSON);
    send_item(ACT_REFRESH, 16'h0000, KIND_VEHICLE);
    send_item(ACT_REFRESH, 16'hA5A5, KIND_PERSON);
    send_item(ACT_LIST, 16'hFFFF, KIND_PERSON);
    send_item(ACT_LIST, 16'h0000, KIND_VEHICLE);
    send_item(ACT_TICK, 16'h5A5A, KIND_VEHICLE);
    send_item(ACT_CLEAR, 16'hFFFF, KIND_VEHICLE);
    send_item(ACT_LIST, 16'h0000, KIND_VEHICLE);
    send_item(ACT_TICK, 16'h0000, KIND_PERSON);
    wait_idle();

    // zero age limit: everything goes on the next tick
    write_age_limit(8'd0);
    send_item(ACT_REFRESH, 16'h1234, KIND_PERSON);
    send_item(ACT_REFRESH, 16'h8765, KIND_VEHICLE);
    send_item(ACT_TICK, 16'h0000, KIND_PERSON);
    send_item(ACT_LIST, 16'h0000, KIND_PERSON);
    wait_idle();

    // largest limit: fill the table and drop one
    write_age_limit(8'd255);
    set_idling(IDLE_SENDER);
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_item(ACT_REFRESH, id_pool[i % ID_POOL_N], logic'(i / ID_POOL_N));
    send_item(ACT_REFRESH, 16'hBEEF, KIND_VEHICLE);
    send_item(ACT_LIST, 16'h0000, KIND_PERSON);
    send_item(ACT_LIST, 16'h0000, KIND_VEHICLE);
    wait_idle();

    // small limit: the full table ages out on the third tick
    write_age_limit(8'd2);
    for (int i = 0; i < 3; i++) send_item(ACT_TICK, '0, KIND_PERSON);
    send_item(ACT_LIST, 16'h0000, KIND_PERSON);
    wait_idle();

    // random phases across limits and idling modes
    for (int p = 0; p < 8; p++) begin
      set_idling(idle_mode_e'(p % 4));
      write_age_limit(phase_limit[p]);
      if (phase_limit[p] == 8'd255) run_random(PHASE_ITEMS, 85, 5, 8);
      else run_random(PHASE_ITEMS, 55, 20, 20);
      wait_idle();
    end

    // back-pressure: the receiver holds off while lists pile up
    set_idling(IDLE_NONE);
    write_age_limit(8'd255);
    send_item(ACT_CLEAR, '0, KIND_PERSON);
    for (int i = 0; i < 24; i++) send_item(ACT_REFRESH, id_pool[i], KIND_PERSON);
    wait_idle();
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_item(ACT_LIST, '0, KIND_PERSON);
      send_item(ACT_TICK, '0, KIND_VEHICLE);
    end
    wait_idle();

    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("PASS aging_sighting_table");
    end else begin
      $display("FAIL aging_sighting_table");
    end
    $finish;
  end

endmodule

### sim.f
src/ast_pkg.sv
src/ast_intf.sv
src/ast_engine.sv
src/aging_sighting_table.sv
sim/aging_sighting_table_test.sv
